FILE: hw/rtl/mfd_pkg.sv
// Shared types and constants for the multichannel fade dimmer.
// Used by the front, queue, back and top-level modules; no dependencies.
package mfd_pkg;

    // channel store geometry
    localparam int CHANNELS = 8;
    localparam int CH_W     = 3;
    localparam int VAL_W    = 8;
    localparam int CMD_W    = 3;
    localparam int IN_CH_W  = 8;

    // request queue between front and back
    localparam int QDEPTH = 2;
    localparam int PTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W  = $clog2(QDEPTH + 1);

    // accumulator full mark
    localparam logic [VAL_W-1:0] ACC_FULL = 8'hFF;

    // command codes on the input channel
    localparam logic [CMD_W-1:0] CMD_TICK       = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SET_LEVEL  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SET_SPEED  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SET_TARGET = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd4;

    // classified operation handed to the back end
    typedef enum logic [2:0] {
        OP_TICK,
        OP_SET_LEVEL,
        OP_SET_SPEED,
        OP_SET_TARGET,
        OP_CLEAR,
        OP_BAD
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [CH_W-1:0]  ch;
        logic [VAL_W-1:0] value;
    } mfd_req_t;

    // back end sequencer states
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_TICK = 2'b10
    } back_state_t;

endpackage

FILE: hw/rtl/mfd_front.sv
// Front end: takes input requests, classifies them and pushes them to the queue.
// Depends on mfd_pkg.
module mfd_front (
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [mfd_pkg::CMD_W-1:0]   command,
    input  logic [mfd_pkg::IN_CH_W-1:0] channel,
    input  logic [mfd_pkg::VAL_W-1:0]   value,
    input  logic                        q_full,
    output logic                        q_push,
    output mfd_pkg::mfd_req_t           q_req
);
    import mfd_pkg::*;

    logic ch_ok;
    logic cmd_known;

    // range check on the channel number
    assign ch_ok = (channel < IN_CH_W'(CHANNELS));

    // decode command into an operation
    always_comb
    begin
        q_req.op    = OP_TICK;
        q_req.ch    = channel[CH_W-1:0];
        q_req.value = value;
        cmd_known   = 1'b1;
        unique case (command)
            CMD_TICK:       q_req.op = OP_TICK;
            CMD_SET_LEVEL:  q_req.op = ch_ok ? OP_SET_LEVEL : OP_BAD;
            CMD_SET_SPEED:  q_req.op = ch_ok ? OP_SET_SPEED : OP_BAD;
            CMD_SET_TARGET: q_req.op = ch_ok ? OP_SET_TARGET : OP_BAD;
            CMD_CLEAR:      q_req.op = OP_CLEAR;
            default:        cmd_known = 1'b0;
        endcase
    end

    // undefined commands are taken and dropped
    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full && cmd_known;

endmodule

FILE: hw/rtl/mfd_fifo.sv
// Short request queue that decouples the front end from the back end.
// Depends on mfd_pkg.
module mfd_fifo (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  mfd_pkg::mfd_req_t         push_req,
    input  logic                      pop,
    output logic                      q_valid,
    output logic                      q_full,
    output mfd_pkg::mfd_req_t         q_head,
    output logic [mfd_pkg::CNT_W-1:0] q_count
);
    import mfd_pkg::*;

    mfd_req_t            slot_reg [QDEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                do_push;
    logic                do_pop;

    assign q_valid = (count_reg != '0);
    assign q_full  = (count_reg == CNT_W'(QDEPTH));
    assign q_head  = slot_reg[rd_ptr_reg];
    assign q_count = count_reg;
    assign do_push = push && !q_full;
    assign do_pop  = pop && q_valid;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_req;
        end
    end

endmodule

FILE: hw/rtl/mfd_back.sv
// Back end: holds the channel store, runs commands and ticks, drives the result register.
// Depends on mfd_pkg.
module mfd_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_valid,
    input  mfd_pkg::mfd_req_t         q_head,
    output logic                      q_pop,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [mfd_pkg::CH_W-1:0]  out_channel,
    output logic [mfd_pkg::VAL_W-1:0] level,
    output logic                      bad_channel,
    output logic                      last
);
    import mfd_pkg::*;

    back_state_t      state_reg;
    back_state_t      state_next;
    logic [CH_W-1:0]  cnt_reg;
    logic [CH_W-1:0]  cnt_next;

    logic [VAL_W-1:0] cur_reg  [CHANNELS];
    logic [VAL_W-1:0] cur_next [CHANNELS];
    logic [VAL_W-1:0] tgt_reg  [CHANNELS];
    logic [VAL_W-1:0] tgt_next [CHANNELS];
    logic [VAL_W-1:0] spd_reg  [CHANNELS];
    logic [VAL_W-1:0] spd_next [CHANNELS];
    logic [VAL_W-1:0] acc_reg  [CHANNELS];
    logic [VAL_W-1:0] acc_next [CHANNELS];

    logic             ovalid_reg;
    logic             ovalid_next;
    logic [CH_W-1:0]  och_reg;
    logic [CH_W-1:0]  och_next;
    logic [VAL_W-1:0] olvl_reg;
    logic [VAL_W-1:0] olvl_next;
    logic             obad_reg;
    logic             obad_next;
    logic             olast_reg;
    logic             olast_next;

    logic             out_free;
    logic             tick_last;
    logic [VAL_W:0]   acc_sum;
    logic             acc_full;
    logic             moving;
    logic [VAL_W-1:0] fade_lvl;
    logic [VAL_W-1:0] fade_acc;

    assign out_free  = !ovalid_reg || !out_stall;
    assign tick_last = (cnt_reg == CH_W'(CHANNELS - 1));

    // fade step for the channel the tick sequencer points at
    always_comb
    begin
        acc_sum  = {1'b0, acc_reg[cnt_reg]} + {1'b0, spd_reg[cnt_reg]};
        acc_full = (acc_sum >= {1'b0, ACC_FULL});
        moving   = (cur_reg[cnt_reg] != tgt_reg[cnt_reg]);
        fade_lvl = cur_reg[cnt_reg];
        fade_acc = acc_reg[cnt_reg];
        if (moving)
        begin
            if (acc_full)
            begin
                fade_acc = '0;
                fade_lvl = (cur_reg[cnt_reg] < tgt_reg[cnt_reg]) ?
                           cur_reg[cnt_reg] + 1'b1 : cur_reg[cnt_reg] - 1'b1;
            end
            else
            begin
                fade_acc = acc_sum[VAL_W-1:0];
            end
        end
    end

    // sequencer, store update and result selection
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        cur_next    = cur_reg;
        tgt_next    = tgt_reg;
        spd_next    = spd_reg;
        acc_next    = acc_reg;
        ovalid_next = ovalid_reg;
        och_next    = och_reg;
        olvl_next   = olvl_reg;
        obad_next   = obad_reg;
        olast_next  = olast_reg;
        q_pop       = 1'b0;
        if (out_free)
        begin
            ovalid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop      = 1'b1;
                    och_next   = q_head.ch;
                    olvl_next  = cur_reg[q_head.ch];
                    obad_next  = 1'b0;
                    olast_next = 1'b1;
                    unique case (q_head.op)
                        OP_TICK:
                        begin
                            state_next = ST_TICK;
                            cnt_next   = '0;
                        end
                        OP_SET_LEVEL:
                        begin
                            cur_next[q_head.ch] = q_head.value;
                            tgt_next[q_head.ch] = q_head.value;
                            olvl_next           = q_head.value;
                            ovalid_next         = 1'b1;
                        end
                        OP_SET_SPEED:
                        begin
                            spd_next[q_head.ch] = q_head.value;
                            ovalid_next         = 1'b1;
                        end
                        OP_SET_TARGET:
                        begin
                            tgt_next[q_head.ch] = q_head.value;
                            ovalid_next         = 1'b1;
                        end
                        OP_CLEAR:
                        begin
                            for (int i = 0; i < CHANNELS; i++)
                            begin
                                cur_next[i] = '0;
                                tgt_next[i] = '0;
                                spd_next[i] = '0;
                                acc_next[i] = '0;
                            end
                            och_next    = '0;
                            olvl_next   = '0;
                            ovalid_next = 1'b1;
                        end
                        OP_BAD:
                        begin
                            och_next    = '0;
                            olvl_next   = '0;
                            obad_next   = 1'b1;
                            ovalid_next = 1'b1;
                        end
                        default:
                        begin
                            ovalid_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_TICK:
            begin
                if (out_free)
                begin
                    cur_next[cnt_reg] = fade_lvl;
                    acc_next[cnt_reg] = fade_acc;
                    och_next          = cnt_reg;
                    olvl_next         = fade_lvl;
                    obad_next         = 1'b0;
                    olast_next        = tick_last;
                    ovalid_next       = 1'b1;
                    cnt_next          = cnt_reg + 1'b1;
                    if (tick_last)
                    begin
                        state_next = ST_IDLE;
                        cnt_next   = '0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state and channel store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                cur_reg[i] <= '0;
                tgt_reg[i] <= '0;
                spd_reg[i] <= '0;
                acc_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
            cur_reg    <= cur_next;
            tgt_reg    <= tgt_next;
            spd_reg    <= spd_next;
            acc_reg    <= acc_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        och_reg   <= och_next;
        olvl_reg  <= olvl_next;
        obad_reg  <= obad_next;
        olast_reg <= olast_next;
    end

    assign out_valid   = ovalid_reg;
    assign out_channel = och_reg;
    assign level       = olvl_reg;
    assign bad_channel = obad_reg;
    assign last        = olast_reg;

endmodule

FILE: hw/rtl/multichannel_fade_dimmer.sv
// Multichannel fade dimmer top level: front end, request queue, back end.
// A set, clear or bad-channel request passes a queue slot, then the result register.
// Throughput: one such request per cycle while the output is not stalled and no tick runs;
// a tick holds the back end while the single fade unit visits the channels in turn.
// Reset (rst_n, async, active low) zeroes every channel's level, target, speed and
// accumulator, empties the queue and drops any pending result.
module multichannel_fade_dimmer (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [mfd_pkg::CMD_W-1:0]   command,
    input  logic [mfd_pkg::IN_CH_W-1:0] channel,
    input  logic [mfd_pkg::VAL_W-1:0]   value,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [mfd_pkg::CH_W-1:0]    out_channel,
    output logic [mfd_pkg::VAL_W-1:0]   level,
    output logic                        bad_channel,
    output logic                        last
);
    import mfd_pkg::*;

    logic             q_full;
    logic             q_push;
    mfd_req_t         q_req;
    logic             q_valid;
    logic             q_pop;
    mfd_req_t         q_head;
    logic [CNT_W-1:0] q_count;

    // request classification
    mfd_front u_front (
        .in_valid (in_valid),
        .in_stall (in_stall),
        .command  (command),
        .channel  (channel),
        .value    (value),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_req    (q_req)
    );

    // request queue
    mfd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_req (q_req),
        .pop      (q_pop),
        .q_valid  (q_valid),
        .q_full   (q_full),
        .q_head   (q_head),
        .q_count  (q_count)
    );

    // execution and result register
    mfd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_channel (out_channel),
        .level       (level),
        .bad_channel (bad_channel),
        .last        (last)
    );

`ifndef NO_ASSERTIONS
    // queue fill never exceeds its depth
    a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= CNT_W'(QDEPTH))
        else $error("request queue overfilled");

    // a bad-channel result is a single zeroed result
    a_bad_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_channel |-> last && out_channel == '0 && level == '0)
        else $error("bad-channel result malformed");

    // the back end only pops a queue that holds a request
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty request queue");

    // a result that is not the last of a tick is followed by the next channel
    a_tick_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=> out_valid
            && out_channel == $past(out_channel) + 1'b1)
        else $error("tick results out of channel order");
`endif

endmodule
